>>> sv/dpbm_pkg.sv
package dpbm_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CH_CNT_W   = 5;
  localparam int THR_W      = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;
  localparam int RST_CHANNELS  = 3;
  localparam int RST_THRESHOLD = 20;

  localparam int EVT_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_CHANNEL_COUNT  = 2'd2,
    REG_DARK_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Classification of one completed pixel, passed from the front to the back.
  typedef struct packed {
    logic dark;
    logic emit_up;
    logic last_row;
    logic last_col;
  } evt_flags_t;

  // Results still owed for the pixel event in the back end.
  typedef struct packed {
    logic up;
    logic left;
    logic self;
  } pend_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             dark;
    logic             boundary;
    logic             last_in_run;
  } result_t;

endpackage

>>> sv/dark_pixel_boundary_mask.sv
// Dark pixel and boundary mask over a multi-channel image stream.
// Input queue: samples arrive in raster order, all channels of a pixel in a
// row; a sample is taken on a clock edge with push high and full low.
// Result queue: while empty is low the oldest result sits on col, row, dark,
// boundary and last_in_run; pop takes it. A pixel is reported once the pixel
// below it is complete; the last row is reported one pixel late and flushed
// at the end of the row, so a completed pixel yields zero to three results.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (width,
// height, channel count, dark threshold); write only when idle.
// Throughput: one sample per cycle while full is low; the back end retires
// one pixel and one result per cycle while the result queue has room, and a
// pixel owing several results holds it until all are out. The first result
// of a completing sample goes via the pixel queue, s2 and the result queue.
// Reset (rst, synchronous) restores 640 x 480, three channels, threshold 20,
// and starts a new frame; the line store needs no clearing pass.
// A stalled result queue fills, then backs up the pixel queue, then raises
// full; nothing is dropped.
module dark_pixel_boundary_mask #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [dpbm_pkg::SAMPLE_W-1:0]   sample,
  output logic                            empty,
  input  logic                            pop,
  output logic [dpbm_pkg::COL_W-1:0]      col,
  output logic [dpbm_pkg::ROW_W-1:0]      row,
  output logic                            dark,
  output logic                            boundary,
  output logic                            last_in_run,
  input  logic                            cfg_we,
  input  logic [dpbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dpbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FLAG_W = $bits(dpbm_pkg::evt_flags_t);
  localparam int EVT_W  = FLAG_W + RW + CW;
  localparam int RES_W  = $bits(dpbm_pkg::result_t);

  // Front: per-sample threshold compare, channel/column/row counting.
  logic                 f_push;
  logic [CW-1:0]        f_col;
  logic [RW-1:0]        f_row;
  dpbm_pkg::evt_flags_t f_flags;

  // Pixel queue between front and back.
  logic                 e_full;
  logic                 e_empty;
  logic                 e_pop;
  logic [EVT_W-1:0]     e_rdata;
  logic [CW-1:0]        e_col;
  logic [RW-1:0]        e_row;
  dpbm_pkg::evt_flags_t e_flags;

  // Result queue at the output.
  logic                 r_push;
  logic                 r_full;
  dpbm_pkg::result_t    r_wdata;
  dpbm_pkg::result_t    r_rdata;

  assign full = e_full;

  dpbm_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .evt_full  (e_full),
    .evt_push  (f_push),
    .evt_col   (f_col),
    .evt_row   (f_row),
    .evt_flags (f_flags)
  );

  dpbm_fifo #(
    .W     (EVT_W),
    .DEPTH (dpbm_pkg::EVT_DEPTH)
  ) u_evt_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wdata ({f_flags, f_row, f_col}),
    .full  (e_full),
    .rd    (e_pop),
    .rdata (e_rdata),
    .empty (e_empty)
  );

  // Unpack the queued pixel request.
  assign e_col   = e_rdata[CW-1:0];
  assign e_row   = e_rdata[CW+RW-1:CW];
  assign e_flags = dpbm_pkg::evt_flags_t'(e_rdata[EVT_W-1:CW+RW]);

  dpbm_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_empty (e_empty),
    .evt_pop   (e_pop),
    .evt_col   (e_col),
    .evt_row   (e_row),
    .evt_flags (e_flags),
    .res_full  (r_full),
    .res_push  (r_push),
    .res       (r_wdata)
  );

  dpbm_fifo #(
    .W     (RES_W),
    .DEPTH (dpbm_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (r_push),
    .wdata (r_wdata),
    .full  (r_full),
    .rd    (pop),
    .rdata (r_rdata),
    .empty (empty)
  );

  // Drive the result ports from the head of the result queue.
  assign col         = r_rdata.col;
  assign row         = r_rdata.row;
  assign dark        = r_rdata.dark;
  assign boundary    = r_rdata.boundary;
  assign last_in_run = r_rdata.last_in_run;

endmodule

>>> sv/dpbm_fifo.sv
module dpbm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

>>> sv/dpbm_front.sv
module dpbm_front #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [dpbm_pkg::SAMPLE_W-1:0]       sample,
  input  logic                                cfg_we,
  input  logic [dpbm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [dpbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                evt_full,
  output logic                                evt_push,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   evt_col,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] evt_row,
  output dpbm_pkg::evt_flags_t                evt_flags
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  function automatic int clamp_lim(int v, int hi);
    int res;
    res = v;
    if (v < 1) begin
      res = 1;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  logic [CHW-1:0]                ch_idx;
  logic                          bright;
  logic [CW-1:0]                 col_cnt;
  logic [RW-1:0]                 row_cnt;
  logic [CW:0]                   w_lim;
  logic [RW:0]                   h_lim;
  logic [CHW:0]                  ch_lim;
  logic [dpbm_pkg::THR_W-1:0]    thr;

  logic          acc;
  logic          bright_now;
  logic [CHW:0]  ch_inc;
  logic          ch_last;
  logic [CW-1:0] c_sat;
  logic [RW-1:0] r_sat;
  logic          col_last;
  logic          row_last;

  assign acc        = push && !evt_full;
  assign bright_now = bright || (sample > thr);
  assign ch_inc     = {1'b0, ch_idx} + (CHW+1)'(1);
  assign ch_last    = !(ch_inc < ch_lim);

  // Counters left past a shrunk frame saturate at the last column or row.
  assign c_sat    = ({1'b0, col_cnt} < w_lim) ? col_cnt : CW'(w_lim - (CW+1)'(1));
  assign r_sat    = ({1'b0, row_cnt} < h_lim) ? row_cnt : RW'(h_lim - (RW+1)'(1));
  assign col_last = !(({1'b0, c_sat} + (CW+1)'(1)) < w_lim);
  assign row_last = !(({1'b0, r_sat} + (RW+1)'(1)) < h_lim);

  assign evt_push           = acc && ch_last;
  assign evt_col            = c_sat;
  assign evt_row            = r_sat;
  assign evt_flags.dark     = !bright_now;
  assign evt_flags.emit_up  = (r_sat != '0);
  assign evt_flags.last_row = row_last;
  assign evt_flags.last_col = col_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx  <= '0;
      bright  <= 1'b0;
      col_cnt <= '0;
      row_cnt <= '0;
      w_lim   <= (CW+1)'(clamp_lim(dpbm_pkg::RST_WIDTH, MAX_WIDTH));
      h_lim   <= (RW+1)'(clamp_lim(dpbm_pkg::RST_HEIGHT, MAX_HEIGHT));
      ch_lim  <= (CHW+1)'(clamp_lim(dpbm_pkg::RST_CHANNELS, MAX_CHANNELS));
      thr     <= dpbm_pkg::THR_W'(dpbm_pkg::RST_THRESHOLD);
    end else begin
      if (cfg_we) begin
        unique case (dpbm_pkg::cfg_reg_t'(cfg_addr))
          dpbm_pkg::REG_IMAGE_WIDTH:
            w_lim <= (CW+1)'(clamp_lim(int'(cfg_wdata[dpbm_pkg::IMG_W_W-1:0]), MAX_WIDTH));
          dpbm_pkg::REG_IMAGE_HEIGHT:
            h_lim <= (RW+1)'(clamp_lim(int'(cfg_wdata[dpbm_pkg::IMG_H_W-1:0]), MAX_HEIGHT));
          dpbm_pkg::REG_CHANNEL_COUNT:
            ch_lim <= (CHW+1)'(clamp_lim(int'(cfg_wdata[dpbm_pkg::CH_CNT_W-1:0]),
                                          MAX_CHANNELS));
          dpbm_pkg::REG_DARK_THRESHOLD:
            thr <= cfg_wdata[dpbm_pkg::THR_W-1:0];
        endcase
      end
      if (acc) begin
        if (ch_last) begin
          ch_idx <= '0;
          bright <= 1'b0;
          if (col_last) begin
            col_cnt <= '0;
            row_cnt <= row_last ? '0 : r_sat + RW'(1);
          end else begin
            col_cnt <= c_sat + CW'(1);
            row_cnt <= r_sat;
          end
        end else begin
          ch_idx <= CHW'(ch_inc);
          bright <= bright_now;
        end
      end
    end
  end

endmodule

>>> sv/dpbm_back.sv
module dpbm_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_empty,
  output logic                 evt_pop,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   evt_col,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] evt_row,
  input  dpbm_pkg::evt_flags_t evt_flags,
  input  logic                 res_full,
  output logic                 res_push,
  output dpbm_pkg::result_t    res
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Two copies of the line store, written alike, for four reads a cycle.
  // Each word holds column c of both row slots, indexed by row parity.
  logic [1:0] mem_lo [MAX_WIDTH];
  logic [1:0] mem_hi [MAX_WIDTH];

  logic                 s2_valid;
  dpbm_pkg::pend_t      s2_pend;
  logic [CW-1:0]        s2_col;
  logic [RW-1:0]        s2_row;
  dpbm_pkg::evt_flags_t s2_flags;
  logic [1:0]           rd_m2;
  logic [1:0]           rd_m1;
  logic [1:0]           rd_0;
  logic [1:0]           rd_p1;

  logic            issue;
  logic            done;
  logic            cur_q;
  logic            cur_p;
  dpbm_pkg::pend_t pend_init;
  dpbm_pkg::pend_t pend_rest;
  logic            self_d;
  logic            bnd;
  logic [CW-1:0]   out_col;
  logic [RW-1:0]   out_row;

  assign pend_init.up   = evt_flags.emit_up;
  assign pend_init.left = evt_flags.last_row && (evt_col != '0);
  assign pend_init.self = evt_flags.last_row && evt_flags.last_col;

  assign cur_q = s2_row[0];
  assign cur_p = !s2_row[0];

  // Pick the oldest owed result: pixel above, then left, then self.
  always_comb begin
    pend_rest = s2_pend;
    self_d    = 1'b0;
    bnd       = 1'b0;
    out_col   = s2_col;
    out_row   = s2_row;
    priority if (s2_pend.up) begin
      pend_rest.up = 1'b0;
      self_d  = rd_0[cur_p];
      out_row = s2_row - RW'(1);
      bnd = !self_d && (((s2_col != '0) && rd_m1[cur_p]) ||
                        (!s2_flags.last_col && rd_p1[cur_p]) ||
                        ((s2_row > RW'(1)) && rd_0[cur_q]) ||
                        s2_flags.dark);
    end else if (s2_pend.left) begin
      pend_rest.left = 1'b0;
      self_d  = rd_m1[cur_q];
      out_col = s2_col - CW'(1);
      bnd = !self_d && (((s2_col > CW'(1)) && rd_m2[cur_q]) ||
                        s2_flags.dark ||
                        ((s2_row != '0) && rd_m1[cur_p]));
    end else if (s2_pend.self) begin
      pend_rest.self = 1'b0;
      self_d = s2_flags.dark;
      bnd = !self_d && (((s2_col != '0) && rd_m1[cur_q]) ||
                        ((s2_row != '0) && rd_0[cur_p]));
    end else begin
      pend_rest = s2_pend;
    end
  end

  assign res_push        = s2_valid && (s2_pend != '0) && !res_full;
  assign res.col         = dpbm_pkg::COL_W'(out_col);
  assign res.row         = dpbm_pkg::ROW_W'(out_row);
  assign res.dark        = self_d;
  assign res.boundary    = bnd;
  assign res.last_in_run = (pend_rest == '0);

  assign done    = s2_valid && ((s2_pend == '0) || (res_push && (pend_rest == '0)));
  assign issue   = !evt_empty && (!s2_valid || done);
  assign evt_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_pend  <= '0;
    end else begin
      if (issue) begin
        s2_valid <= 1'b1;
        s2_pend  <= pend_init;
      end else begin
        if (done) begin
          s2_valid <= 1'b0;
        end
        if (res_push) begin
          s2_pend <= pend_rest;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_col   <= evt_col;
      s2_row   <= evt_row;
      s2_flags <= evt_flags;
    end
  end

  // Read before write: column c returns the row two above, then takes this row.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_m2 <= mem_lo[evt_col - CW'(2)];
      rd_m1 <= mem_lo[evt_col - CW'(1)];
      mem_lo[evt_col][evt_row[0]] <= evt_flags.dark;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_0  <= mem_hi[evt_col];
      rd_p1 <= mem_hi[evt_col + CW'(1)];
      mem_hi[evt_col][evt_row[0]] <= evt_flags.dark;
    end
  end

endmodule

>>> verif/mask_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the mask block, keeps
// its own copy of the frame counters and the two-row dark store, and checks
// every popped result against the oldest one still owed.
module mask_checker #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [dpbm_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [dpbm_pkg::COL_W-1:0]      col,
  input  logic [dpbm_pkg::ROW_W-1:0]      row,
  input  logic                            dark,
  input  logic                            boundary,
  input  logic                            last_in_run,
  input  logic                            cfg_we,
  input  logic [dpbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dpbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);

  localparam int MAX_PRINTED = 40;

  logic [dpbm_pkg::IMG_W_W-1:0]  width_reg;
  logic [dpbm_pkg::IMG_H_W-1:0]  height_reg;
  logic [dpbm_pkg::CH_CNT_W-1:0] chans_reg;
  logic [dpbm_pkg::THR_W-1:0]    thresh_reg;

  int                chan_pos;
  int                col_pos;
  int                row_pos;
  bit                bright_seen;
  bit                dark_rows [2*MAX_WIDTH];
  dpbm_pkg::result_t owed_masks[$];
  int                fail_count;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Rows alternate between the two halves of the store by parity.
  function automatic bit row_dark(int r, int c);
    return dark_rows[(r & 1) * MAX_WIDTH + c];
  endfunction

  function automatic dpbm_pkg::result_t describe(int r, int c, int w, int h,
                                                 bit self_dark, bit lower_dark);
    dpbm_pkg::result_t res;
    bit                near_dark;
    near_dark = 1'b0;
    if (!self_dark) begin
      if (c > 0 && row_dark(r, c - 1)) near_dark = 1'b1;
      if (c + 1 < w && row_dark(r, c + 1)) near_dark = 1'b1;
      if (r > 0 && row_dark(r - 1, c)) near_dark = 1'b1;
      if (r + 1 < h && lower_dark) near_dark = 1'b1;
    end
    res.col         = dpbm_pkg::COL_W'(c);
    res.row         = dpbm_pkg::ROW_W'(r);
    res.dark        = self_dark;
    res.boundary    = near_dark;
    res.last_in_run = 1'b0;
    return res;
  endfunction

  task automatic take_sample(input logic [dpbm_pkg::SAMPLE_W-1:0] s);
    int                w;
    int                h;
    int                nch;
    int                r;
    int                c;
    int                n;
    bit                d;
    dpbm_pkg::result_t run [3];
    w   = clamp_to(int'(width_reg), MAX_WIDTH);
    h   = clamp_to(int'(height_reg), MAX_HEIGHT);
    nch = clamp_to(int'(chans_reg), MAX_CHANNELS);
    n   = 0;
    if (s > thresh_reg) bright_seen = 1'b1;
    if (chan_pos + 1 < nch) begin
      chan_pos++;
      return;
    end
    // Pixel complete: counters left past a shrunken frame saturate.
    chan_pos    = 0;
    d           = !bright_seen;
    bright_seen = 1'b0;
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h - 1;
    if (r > 0) begin
      run[n] = describe(r - 1, c, w, h, row_dark(r - 1, c), d);
      n++;
    end
    dark_rows[(r & 1) * MAX_WIDTH + c] = d;
    if (r + 1 >= h) begin
      if (c > 0) begin
        run[n] = describe(r, c - 1, w, h, row_dark(r, c - 1), 1'b0);
        n++;
      end
      if (c + 1 >= w) begin
        run[n] = describe(r, c, w, h, d, 1'b0);
        n++;
      end
    end
    if (n > 0) run[n-1].last_in_run = 1'b1;
    for (int k = 0; k < n; k++) owed_masks.push_back(run[k]);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("[%0t] mask mismatch: %s", $time, what);
  endtask

  task automatic check_mask();
    dpbm_pkg::result_t want;
    if (owed_masks.size() == 0) begin
      report_mismatch($sformatf("result (%0d,%0d) popped with nothing owed", row, col));
      return;
    end
    want = owed_masks.pop_front();
    if (col != want.col)
      report_mismatch($sformatf("col %0d, expected %0d", col, want.col));
    if (row != want.row)
      report_mismatch($sformatf("row %0d, expected %0d", row, want.row));
    if (dark != want.dark)
      report_mismatch($sformatf("pixel (%0d,%0d) dark %0b, expected %0b",
                                want.row, want.col, dark, want.dark));
    if (boundary != want.boundary)
      report_mismatch($sformatf("pixel (%0d,%0d) boundary %0b, expected %0b",
                                want.row, want.col, boundary, want.boundary));
    if (last_in_run != want.last_in_run)
      report_mismatch($sformatf("pixel (%0d,%0d) last_in_run %0b, expected %0b",
                                want.row, want.col, last_in_run, want.last_in_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = dpbm_pkg::IMG_W_W'(dpbm_pkg::RST_WIDTH);
      height_reg  = dpbm_pkg::IMG_H_W'(dpbm_pkg::RST_HEIGHT);
      chans_reg   = dpbm_pkg::CH_CNT_W'(dpbm_pkg::RST_CHANNELS);
      thresh_reg  = dpbm_pkg::THR_W'(dpbm_pkg::RST_THRESHOLD);
      chan_pos    = 0;
      col_pos     = 0;
      row_pos     = 0;
      bright_seen = 1'b0;
      foreach (dark_rows[i]) dark_rows[i] = 1'b0;
      owed_masks.delete();
    end else begin
      if (pop && !empty) check_mask();
      if (cfg_we) begin
        case (dpbm_pkg::cfg_reg_t'(cfg_addr))
          dpbm_pkg::REG_IMAGE_WIDTH:
            width_reg  = cfg_wdata[dpbm_pkg::IMG_W_W-1:0];
          dpbm_pkg::REG_IMAGE_HEIGHT:
            height_reg = cfg_wdata[dpbm_pkg::IMG_H_W-1:0];
          dpbm_pkg::REG_CHANNEL_COUNT:
            chans_reg  = cfg_wdata[dpbm_pkg::CH_CNT_W-1:0];
          dpbm_pkg::REG_DARK_THRESHOLD:
            thresh_reg = cfg_wdata[dpbm_pkg::THR_W-1:0];
        endcase
      end
      if (push && !full) take_sample(sample);
    end
    errors  <= fail_count;
    pending <= owed_masks.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Cycles with no request moving on either side before the run is abandoned.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;
  // Pixels that yield no result may still sit in the block once nothing is
  // owed; give them time to retire before touching a register.
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 64;

  logic                            clk;
  logic                            rst;
  logic                            push;
  logic                            full;
  logic [dpbm_pkg::SAMPLE_W-1:0]   sample;
  logic                            empty;
  logic                            pop;
  logic [dpbm_pkg::COL_W-1:0]      col;
  logic [dpbm_pkg::ROW_W-1:0]      row;
  logic                            dark;
  logic                            boundary;
  logic                            last_in_run;
  logic                            cfg_we;
  logic [dpbm_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [dpbm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int errors;
  int pending;
  int send_idle_pct;
  int pop_stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int sent_items;

  dark_pixel_boundary_mask DUT (.*);

  mask_checker mask_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: pop at random per the current stall rate. A hold request from
  // the stimulus side starts a long stretch with pop low, counted here.
  initial begin
    pop <= 1'b0;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Watchdog: reset the count whenever a request moves on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offer one sample, idling first at the current rate, and hold it until
  // taken. push stays high on return so back-to-back requests need no gap.
  task automatic send_sample(input int s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    sample <= dpbm_pkg::SAMPLE_W'(s);
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
  endtask

  // Drop push, wait for every owed result, then let stragglers retire.
  task automatic settle();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(input dpbm_pkg::cfg_reg_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= dpbm_pkg::CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic write_one(input dpbm_pkg::cfg_reg_t idx, input int value);
    settle();
    write_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w_reg, input int h_reg, input int ch_reg,
                           input int thr_reg);
    settle();
    write_reg(dpbm_pkg::REG_IMAGE_WIDTH, w_reg);
    write_reg(dpbm_pkg::REG_IMAGE_HEIGHT, h_reg);
    write_reg(dpbm_pkg::REG_CHANNEL_COUNT, ch_reg);
    write_reg(dpbm_pkg::REG_DARK_THRESHOLD, thr_reg);
    cfg_we <= 1'b0;
  endtask

  // A dark pixel, or any pixel at threshold 255, keeps every channel at or
  // under it; a bright one pushes one chosen channel above it, the rest random.
  task automatic send_pixel(input bit want_dark, input int nch, input int thr);
    int bright_ch;
    int s;
    bright_ch = $urandom_range(nch - 1, 0);
    for (int i = 0; i < nch; i++) begin
      if (want_dark || thr == 255) s = $urandom_range(thr, 0);
      else if (i == bright_ch) s = $urandom_range(255, thr + 1);
      else s = $urandom_range(255, 0);
      send_sample(s);
    end
  endtask

  // One whole frame with random geometry, mostly small. Register values out
  // of range show up now and then and are sized by their clamped value.
  task automatic random_frame(input bit noisy);
    int w_reg;
    int h_reg;
    int ch_reg;
    int thr;
    int nch;
    int pixels;
    int dark_pct;
    int pick;
    pick  = $urandom_range(99);
    w_reg = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(6, 1) : $urandom_range(24, 7);
    pick  = $urandom_range(99);
    h_reg = (pick < 5) ? 0 : $urandom_range(5, 1);
    pick  = $urandom_range(99);
    ch_reg = (pick < 70) ? $urandom_range(3, 1) :
             (pick < 90) ? $urandom_range(8, 4) : $urandom_range(31, 16);
    pick  = $urandom_range(99);
    thr   = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255, 0);
    pixels = clamp_to(w_reg, 1024) * clamp_to(h_reg, 4096);
    nch    = clamp_to(ch_reg, 16);
    if (pixels * nch > 120) begin
      ch_reg = 1;
      nch    = 1;
    end
    set_frame(w_reg, h_reg, ch_reg, thr);
    dark_pct = $urandom_range(70, 20);
    for (int p = 0; p < pixels; p++) begin
      if (noisy) begin
        for (int i = 0; i < nch; i++) send_sample($urandom_range(255, 0));
      end else begin
        send_pixel($urandom_range(99) < dark_pct, nch, thr);
      end
    end
  endtask

  initial begin
    int phase_start;
    rst           <= 1'b1;
    push          <= 1'b0;
    sample        <= '0;
    cfg_we        <= 1'b0;
    cfg_addr      <= dpbm_pkg::REG_IMAGE_WIDTH;
    cfg_wdata     <= '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_requests = 0;
    sent_items    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // 2x2, threshold zero: only a zero sample is dark.
    set_frame(2, 2, 1, 0);
    send_sample(0);
    send_sample(255);
    send_sample(1);
    send_sample(0);

    // Single pixel, threshold at maximum: a full-scale sample is still dark.
    set_frame(1, 1, 2, 255);
    send_sample(255);
    send_sample(255);

    // Zero width and channel count clamp up to one; height 8191 clamps to
    // 4096. Shrink the height after three rows so the row counter sits past
    // the frame and saturates onto the last row, ending the frame.
    set_frame(0, 8191, 0, 128);
    send_sample(129);
    send_sample(128);
    send_sample(0);
    write_one(dpbm_pkg::REG_IMAGE_HEIGHT, 2);
    send_sample(127);

    // Channel count 31 clamps to 16: the pixel closes on its sixteenth sample.
    set_frame(1, 1, 31, 200);
    for (int i = 0; i < 15; i++) send_sample($urandom_range(200, 0));
    send_sample(201);

    // Width 2047 clamps to 1024; shrink to two with the column counter at
    // three, so the pixel lands on the last column and flushes the row.
    set_frame(2047, 1, 1, 20);
    send_sample(21);
    send_sample(20);
    send_sample(0);
    write_one(dpbm_pkg::REG_IMAGE_WIDTH, 2);
    send_sample(255);

    // Shrink the channel count under the channel counter mid-pixel.
    set_frame(1, 1, 4, 20);
    send_sample(0);
    send_sample(0);
    send_sample(0);
    write_one(dpbm_pkg::REG_CHANNEL_COUNT, 2);
    send_sample(21);

    // Random frames under four idling mixes: none, sender mostly idle,
    // receiver mostly stalled, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 88; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 88; end
        default: begin send_idle_pct = 16; pop_stall_pct = 16; end
      endcase
      if (phase == 0) begin
        // Hold off the receiver while a full frame streams in, so the result
        // queue fills and full backs up to the sample side.
        set_frame(8, 4, 1, 50);
        hold_requests++;
        for (int p = 0; p < 32; p++) send_pixel($urandom_range(99) < 40, 1, 50);
      end
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS)
        random_frame($urandom_range(99) < 15);
    end

    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
